// ----- design/fvt_pkg.sv -----
package fvt_pkg;

	localparam int POS_W      = 16;
	localparam int COEF_W     = 16;
	localparam int COEF_FRAC  = 12;
	localparam int POS_FRAC   = 8;

	localparam int CFG_IDX_W  = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INV    = 3'd6;

	// homogeneous accumulator and divider widths
	localparam int ACC_W   = 34;
	localparam int NUM_W   = 44;
	localparam int DEN_W   = 35;
	localparam int QUOT_W  = 16;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] out_x;
		logic signed [POS_W-1:0] out_y;
		logic signed [POS_W-1:0] out_z;
		logic                    range_flag;
	} out_t;

	typedef struct packed {
		logic             mode;
		logic [3:0][63:0] row;
		logic [47:0]      origin;
		logic [15:0]      inv_radius_sq;
	} cfg_t;

	// blended matrix plus the vertex, handed from front to back
	typedef struct packed {
		in_t                          pos;
		logic [3:0][3:0][COEF_W-1:0] e;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- design/fvt_front.sv -----
module fvt_front import fvt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic job_valid,
	input  logic job_ready,
	output job_t job
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	in_t  pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6, pos_s7;

	logic [2:0][16:0] dmag;
	logic [2:0][16:0] dmag_s1;
	logic [2:0][31:0] sq_s2;
	logic [33:0]      d2_s3;
	logic [49:0]      prod_s4;
	logic [24:0]      c24;
	logic [25:0]      c_rnd;
	logic [12:0]      c_s5, c_s6;
	logic signed [28:0] mc_s6 [4][4];
	logic signed [29:0] bl [4][4];
	logic [3:0][3:0][COEF_W-1:0] e_s7;

	assign adv      = !v_s7 || job_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// distance magnitude per axis, never above 65535 so no clamp is needed
	always_comb begin
		logic signed [16:0] p3 [3];
		logic signed [16:0] o3 [3];
		logic signed [16:0] diff;
		p3[0] = 17'(in_data.pos_x);
		p3[1] = 17'(in_data.pos_y);
		p3[2] = 17'(in_data.pos_z);
		for (int k = 0; k < 3; k++) begin
			o3[k] = 17'($signed(cfg.origin[16*k +: 16]));
		end
		for (int k = 0; k < 3; k++) begin
			diff    = p3[k] - o3[k];
			dmag[k] = diff[16] ? 17'(-diff) : 17'(diff);
		end
	end

	always_comb begin
		c24   = (prod_s4[49:24] != '0) ? 25'd0 : 25'd16777216 - {1'b0, prod_s4[23:0]};
		c_rnd = {1'b0, c24} + 26'd2048;
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				bl[i][j] = 30'(mc_s6[i][j]) + 30'sd2048;
				if (i == j) begin
					bl[i][j] = bl[i][j] + $signed({5'b0, 13'd4096 - c_s6, 12'b0});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1  <= in_data;
			dmag_s1 <= dmag;

			pos_s2 <= pos_s1;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= 32'({15'd0, dmag_s1[k]} * {15'd0, dmag_s1[k]});
			end

			pos_s3 <= pos_s2;
			d2_s3  <= {2'b0, sq_s2[0]} + {2'b0, sq_s2[1]} + {2'b0, sq_s2[2]};

			pos_s4  <= pos_s3;
			prod_s4 <= {16'b0, d2_s3} * {34'b0, cfg.inv_radius_sq};

			// full matrix is the blend with weight one
			pos_s5 <= pos_s4;
			c_s5   <= cfg.mode ? c_rnd[24:12] : 13'd4096;

			pos_s6 <= pos_s5;
			c_s6   <= c_s5;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					mc_s6[i][j] <= 29'($signed(cfg.row[i][16*j +: COEF_W])
						* $signed({1'b0, c_s5}));
				end
			end

			pos_s7 <= pos_s6;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					e_s7[i][j] <= bl[i][j][27:12];
				end
			end
		end
	end

	assign job_valid = v_s7;
	assign job.pos   = pos_s7;
	assign job.e     = e_s7;

endmodule

// ----- design/fvt_fifo.sv -----
module fvt_fifo import fvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       push_data,
	input  logic       pop,
	output job_t       pop_data,
	output fifo_stat_t stat
);

	job_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push, do_pop;

	assign stat.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ----- design/fvt_back.sv -----
module fvt_back import fvt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [2:0]       neg;
		logic [2:0]       ovf;
		logic             zw;
	} div_ctl_t;

	logic adv;
	logic v_s1, v_s2;
	logic out_valid_q;
	out_t out_q, out_d;

	logic signed [31:0]      pr_s1 [4][4];
	logic signed [ACC_W-1:0] a_s2 [4];
	logic [ACC_W-1:0]        absa [4];
	logic [NUM_W-1:0]        num [3];
	logic [DEN_W-1:0]        den;

	logic                vd_s  [QUOT_W+1];
	div_ctl_t            dv_s  [QUOT_W+1];
	logic [NUM_W-1:0]    rem_s [QUOT_W+1][3];
	logic [QUOT_W-1:0]   q_s   [QUOT_W+1][3];

	assign adv     = !out_valid_q || out_ready;
	assign job_pop = adv && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			vd_s[0]     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= job_valid;
			v_s2        <= v_s1;
			vd_s[0]     <= v_s2;
			out_valid_q <= vd_s[QUOT_W];
		end
	end

	// matrix times (x, y, z, 1); w enters as 1.0 in Q8.8
	always_ff @(posedge clk) begin
		logic signed [POS_W-1:0] p [3];
		p[0] = job.pos.pos_x;
		p[1] = job.pos.pos_y;
		p[2] = job.pos.pos_z;
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr_s1[i][j] <= 32'($signed(job.e[i][j]) * p[j]);
				end
				pr_s1[i][3] <= $signed({{8{job.e[i][3][COEF_W-1]}}, job.e[i][3], 8'b0});
			end
			for (int i = 0; i < 4; i++) begin
				a_s2[i] <= ACC_W'(pr_s1[i][0]) + ACC_W'(pr_s1[i][1])
					+ ACC_W'(pr_s1[i][2]) + ACC_W'(pr_s1[i][3]);
			end
		end
	end

	// rounded quotient: floor((2*|a|*256 + |w|) / (2*|w|))
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			absa[i] = a_s2[i][ACC_W-1] ? ACC_W'(-a_s2[i]) : ACC_W'(a_s2[i]);
		end
		den = {absa[3], 1'b0};
		for (int i = 0; i < 3; i++) begin
			num[i] = NUM_W'({absa[i], 9'b0}) + NUM_W'(absa[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0].den <= den;
			dv_s[0].zw  <= (a_s2[3] == '0);
			for (int i = 0; i < 3; i++) begin
				dv_s[0].neg[i] <= a_s2[i][ACC_W-1] ^ a_s2[3][ACC_W-1];
				dv_s[0].ovf[i] <= {7'b0, num[i]} >= {den, 16'b0};
				rem_s[0][i]    <= num[i];
				q_s[0][i]      <= '0;
			end
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar k = 0; k < QUOT_W; k++) begin : g_div
		localparam int SH = QUOT_W - 1 - k;
		logic [50:0] trial;
		assign trial = 51'(dv_s[k].den) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[k+1] <= 1'b0;
			end else if (adv) begin
				vd_s[k+1] <= vd_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1] <= dv_s[k];
				for (int i = 0; i < 3; i++) begin
					if ({7'b0, rem_s[k][i]} >= trial) begin
						rem_s[k+1][i] <= rem_s[k][i] - trial[NUM_W-1:0];
						q_s[k+1][i]   <= q_s[k][i] | (QUOT_W'(1) << SH);
					end else begin
						rem_s[k+1][i] <= rem_s[k][i];
						q_s[k+1][i]   <= q_s[k][i];
					end
				end
			end
		end
	end

	always_comb begin
		logic [QUOT_W-1:0]       mag;
		logic signed [POS_W-1:0] val [3];
		logic                    flag;
		flag = 1'b0;
		for (int i = 0; i < 3; i++) begin
			mag = q_s[QUOT_W][i];
			if (dv_s[QUOT_W].zw) begin
				val[i] = '0;
				flag   = 1'b1;
			end else if (dv_s[QUOT_W].neg[i]) begin
				if (dv_s[QUOT_W].ovf[i] || mag > 16'd32768) begin
					val[i] = 16'sh8000;
					flag   = 1'b1;
				end else begin
					val[i] = POS_W'(-$signed({1'b0, mag}));
				end
			end else begin
				if (dv_s[QUOT_W].ovf[i] || mag > 16'd32767) begin
					val[i] = 16'sh7fff;
					flag   = 1'b1;
				end else begin
					val[i] = $signed(mag);
				end
			end
		end
		out_d.out_x      = val[0];
		out_d.out_y      = val[1];
		out_d.out_z      = val[2];
		out_d.range_flag = flag;
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- design/falloff_vertex_transform_top.sv -----
// Vertex transform: each (x, y, z) Q8.8 vertex is multiplied by a 4x4 Q4.12 matrix with
// w = 1, optionally blended toward identity by a quadratic distance falloff, then divided
// by w with round-to-nearest; results saturate and raise range_flag (also on zero w).
// One vertex per cycle sustained while out_ready stays high. A vertex passes through the
// falloff/blend front, then the 4-entry queue, then the back stages in order:
// product, sum and divider setup, a 16-stage restoring divider (one quotient bit per
// stage), then the output register. Config writes are taken every cycle and must only
// occur while the block is drained.
module falloff_vertex_transform_top import fvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	cfg_t       cfg_q;
	logic       front_valid;
	job_t       front_job, back_job;
	logic       job_pop;
	fifo_stat_t fstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= 1'b0;
			cfg_q.row[0]        <= 64'h0000_0000_0000_1000;
			cfg_q.row[1]        <= 64'h0000_0000_1000_0000;
			cfg_q.row[2]        <= 64'h0000_1000_0000_0000;
			cfg_q.row[3]        <= 64'h1000_0000_0000_0000;
			cfg_q.origin        <= '0;
			cfg_q.inv_radius_sq <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode          <= cfg_data[0];
				REG_ROW0:   cfg_q.row[0]        <= cfg_data;
				REG_ROW1:   cfg_q.row[1]        <= cfg_data;
				REG_ROW2:   cfg_q.row[2]        <= cfg_data;
				REG_ROW3:   cfg_q.row[3]        <= cfg_data;
				REG_ORIGIN: cfg_q.origin        <= cfg_data[47:0];
				REG_INV:    cfg_q.inv_radius_sq <= cfg_data[15:0];
				default:    cfg_q.mode          <= cfg_q.mode;
			endcase
		end
	end

	fvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (front_valid),
		.job_ready (!fstat.full),
		.job       (front_job)
	);

	fvt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_job),
		.pop       (job_pop),
		.pop_data  (back_job),
		.stat      (fstat)
	);

	fvt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!fstat.empty),
		.job       (back_job),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// back never pulls from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !fstat.empty)
		else $error("queue popped while empty");

	// a full queue with a finished front item must stall the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(fstat.full && front_valid) |-> !in_ready)
		else $error("input accepted while queue blocked");

	// a transfer into a full queue cannot leave it less than full next cycle without a pop
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fstat.full && !job_pop) |=> fstat.full)
		else $error("queue entry lost");

endmodule

// ----- verif/falloff_vertex_transform_top_tb.sv -----
`timescale 1ns / 100ps

module falloff_vertex_transform_top_tb;
	import fvt_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;

	falloff_vertex_transform_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// shadow copy of the block's registers
	logic        mode_q;
	logic [63:0] rows_q [4];
	logic [47:0] origin_q;
	logic [15:0] inv_q;

	out_t        expected_vertices [$];
	int          mismatches;
	int          unexpected;
	logic        sender_idle_en;
	logic        receiver_idle_en;
	logic        hold_off;
	int          hold_cycles;
	int          rx_idle_left;
	longint      cycle_cnt = 0;

	localparam longint CYCLE_LIMIT = 1000000;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic longint sx16(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint floor_div4096(longint v);
		return v >>> 12;
	endfunction

	function automatic out_t transform_vertex(in_t v);
		longint p [4];
		longint e [4][4];
		longint a [4];
		longint c, d, d2, prod, c24, id, num, den, mag, q;
		logic   neg, flag;
		out_t   r;
		p[0] = longint'(v.pos_x);
		p[1] = longint'(v.pos_y);
		p[2] = longint'(v.pos_z);
		p[3] = 256;
		c = 4096;
		flag = 1'b0;
		if (mode_q) begin
			d2 = 0;
			for (int i = 0; i < 3; i++) begin
				d = p[i] - sx16(origin_q[16*i +: 16]);
				if (d < 0) d = -d;
				if (d > 65536) d = 65536;
				d2 += d * d;
			end
			prod = d2 * longint'(inv_q);
			c24 = (prod >= (64'sd1 << 24)) ? 0 : (64'sd1 << 24) - prod;
			c = (c24 + 2048) >> 12;
		end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				e[i][j] = sx16(rows_q[i][16*j +: 16]);
				if (mode_q) begin
					id = (i == j) ? 4096 : 0;
					e[i][j] = floor_div4096(id * (4096 - c) + e[i][j] * c + 2048);
				end
			end
		for (int i = 0; i < 4; i++) begin
			a[i] = 0;
			for (int j = 0; j < 4; j++)
				a[i] += e[i][j] * p[j];
		end
		for (int i = 0; i < 3; i++) begin
			q = 0;
			if (a[3] == 0) begin
				flag = 1'b1;
			end else begin
				neg = (a[i] < 0) != (a[3] < 0);
				num = ((a[i] < 0) ? -a[i] : a[i]) << 8;
				den = (a[3] < 0) ? -a[3] : a[3];
				mag = (2 * num + den) / (2 * den);
				q = neg ? -mag : mag;
				if (q > 32767) begin q = 32767; flag = 1'b1; end
				if (q < -32768) begin q = -32768; flag = 1'b1; end
			end
			case (i)
				0: r.out_x = q[15:0];
				1: r.out_y = q[15:0];
				default: r.out_z = q[15:0];
			endcase
		end
		r.range_flag = flag;
		return r;
	endfunction

	// receiver: random idle bursts, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
			rx_idle_left <= 0;
		end else if (hold_off && hold_cycles < 300) begin
			hold_cycles <= hold_cycles + 1;
			out_ready <= 1'b0;
		end else if (rx_idle_left > 0) begin
			rx_idle_left <= rx_idle_left - 1;
			out_ready <= 1'b0;
		end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
			rx_idle_left <= int'($urandom_range(0, 6));
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_t exp_v;
		if (arst_n && out_valid && out_ready) begin
			if (expected_vertices.size() == 0) begin
				unexpected++;
				if (unexpected <= 10)
					$display("unexpected transfer %h", out_data);
			end else begin
				exp_v = expected_vertices.pop_front();
				if (out_data.out_x !== exp_v.out_x || out_data.out_y !== exp_v.out_y ||
						out_data.out_z !== exp_v.out_z ||
						out_data.range_flag !== exp_v.range_flag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%h y=%h z=%h f=%b got x=%h y=%h z=%h f=%b",
							exp_v.out_x, exp_v.out_y, exp_v.out_z, exp_v.range_flag,
							out_data.out_x, out_data.out_y, out_data.out_z,
							out_data.range_flag);
				end
			end
		end
	end

	// valid stays high between back-to-back items; drain_results drops it
	task automatic send_vertex(in_t v);
		int gap;
		cfg_valid <= 1'b0;
		if (sender_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		do @(posedge clk); while (!in_ready);
		expected_vertices = {expected_vertices, transform_vertex(v)};
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:   mode_q = val[0];
			REG_ROW0:   rows_q[0] = val;
			REG_ROW1:   rows_q[1] = val;
			REG_ROW2:   rows_q[2] = val;
			REG_ROW3:   rows_q[3] = val;
			REG_ORIGIN: origin_q = val[47:0];
			REG_INV:    inv_q = val[15:0];
			default: ;
		endcase
	endtask

	function automatic in_t rand_vertex(int span);
		in_t v;
		if (span >= 32768) begin
			v.pos_x = 16'($urandom);
			v.pos_y = 16'($urandom);
			v.pos_z = 16'($urandom);
		end else begin
			v.pos_x = 16'($urandom_range(0, 2 * span) - span);
			v.pos_y = 16'($urandom_range(0, 2 * span) - span);
			v.pos_z = 16'($urandom_range(0, 2 * span) - span);
		end
		return v;
	endfunction

	function automatic logic [63:0] rand_row(int diag);
		logic [63:0] r;
		for (int j = 0; j < 4; j++)
			r[16*j +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 2048) - 1024 + ((j == diag) ? 4096 : 0));
		return r;
	endfunction

	task automatic test_identity_extremes();
		in_t v;
		logic [15:0] ext [5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
		for (int i = 0; i < 5; i++) begin
			v.pos_x = ext[i]; v.pos_y = ext[(i + 1) % 5]; v.pos_z = ext[(i + 2) % 5];
			send_vertex(v);
		end
		drain_results();
	endtask

	task automatic test_special_w();
		// zero w, then negative w, then a w row that scales down hard, then extreme rows
		write_reg(REG_ROW3, 64'h0);
		send_vertex('{16'h0100, 16'hff00, 16'h7fff});
		drain_results();
		write_reg(REG_ROW3, {16'hf000, 16'h0, 16'h0, 16'h0});
		send_vertex('{16'h0100, 16'hff00, 16'h1234});
		drain_results();
		write_reg(REG_ROW3, {16'h0001, 16'h0, 16'h0, 16'h0});
		send_vertex('{16'h0100, 16'hff00, 16'h0000});
		drain_results();
		write_reg(REG_ROW0, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_ROW1, 64'h8000_8000_8000_8000);
		write_reg(REG_ROW2, 64'h7fff_7fff_7fff_7fff);
		write_reg(REG_ROW3, 64'h7fff_8000_7fff_8000);
		send_vertex('{16'h8000, 16'h7fff, 16'h8000});
		send_vertex('{16'h7fff, 16'h7fff, 16'h7fff});
		drain_results();
	endtask

	task automatic test_falloff_directed();
		write_reg(REG_MODE, 64'h1);
		write_reg(REG_ORIGIN, 64'h0000_0000_0000_0000);
		write_reg(REG_INV, 64'h0);
		send_vertex('{16'h7fff, 16'h8000, 16'h0100});
		drain_results();
		write_reg(REG_INV, 64'hffff);
		send_vertex('{16'h0000, 16'h0000, 16'h0000});
		send_vertex('{16'h0001, 16'h0000, 16'h0000});
		drain_results();
		write_reg(REG_ORIGIN, 64'h0000_8000_7fff_8000);
		write_reg(REG_INV, 64'h0100);
		send_vertex('{16'h7fff, 16'h8000, 16'h7fff});
		send_vertex('{16'h8000, 16'h7fff, 16'h8000});
		drain_results();
		// unknown index is ignored
		write_reg(REG_UNUSED, 64'hdead_beef_dead_beef);
		write_reg(REG_MODE, 64'h0);
		send_vertex('{16'h0200, 16'h0300, 16'h0400});
		drain_results();
	endtask

	task automatic test_random_phases();
		int span;
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_MODE, 64'($urandom_range(0, 1)));
			for (int i = 0; i < 4; i++)
				write_reg(CFG_IDX_W'(int'(REG_ROW0) + i), rand_row(i));
			write_reg(REG_ORIGIN, 64'({16'($urandom_range(0, 2048) - 1024),
				16'($urandom_range(0, 2048) - 1024), 16'($urandom_range(0, 2048) - 1024)}));
			write_reg(REG_INV, ph == 9 ? 64'hffff : 64'($urandom_range(0, 3) == 0 ?
				$urandom_range(0, 65535) : $urandom_range(0, 64)));
			for (int n = 0; n < 150; n++) begin
				span = ($urandom_range(0, 9) == 0) ? 32768 : $urandom_range(1, 4096);
				send_vertex(rand_vertex(span));
			end
			drain_results();
		end
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int n = 0; n < 60; n++) send_vertex(rand_vertex(2048));
		hold_off = 1'b0;
		drain_results();
	endtask

	task automatic test_streaming();
		sender_idle_en = 1'b0;
		receiver_idle_en = 1'b0;
		for (int n = 0; n < 120; n++) send_vertex(rand_vertex(($urandom_range(0, 7) == 0)
			? 32768 : 3000));
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		mismatches = 0;
		unexpected = 0;
		hold_off = 1'b0;
		sender_idle_en = 1'b1;
		receiver_idle_en = 1'b1;
		mode_q = 1'b0;
		rows_q[0] = 64'd4096;
		rows_q[1] = 64'd4096 << 16;
		rows_q[2] = 64'd4096 << 32;
		rows_q[3] = 64'd4096 << 48;
		origin_q = '0;
		inv_q = 16'd256;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_extremes();
		test_special_w();
		test_falloff_directed();
		test_backpressure();
		test_random_phases();
		test_streaming();
		if (mismatches == 0 && unexpected == 0 && expected_vertices.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
design/fvt_pkg.sv
design/fvt_front.sv
design/fvt_fifo.sv
design/fvt_back.sv
design/falloff_vertex_transform_top.sv
verif/falloff_vertex_transform_top_tb.sv
